// ===== hdl/tcf_pkg.sv =====
// Shared types and constants for the Telnet command filter.
// Holds protocol codes, the parser-to-expander item format and the AYT reply table.
// No dependencies.
package tcf_pkg;

  localparam logic [7:0] CODE_IAC   = 8'd255;
  localparam logic [7:0] CODE_DONT  = 8'd254;
  localparam logic [7:0] CODE_DO    = 8'd253;
  localparam logic [7:0] CODE_WONT  = 8'd252;
  localparam logic [7:0] CODE_WILL  = 8'd251;
  localparam logic [7:0] CODE_SB    = 8'd250;
  localparam logic [7:0] CODE_AYT   = 8'd246;
  localparam logic [7:0] CODE_IP    = 8'd244;
  localparam logic [7:0] CODE_BREAK = 8'd243;
  localparam logic [7:0] CODE_SE    = 8'd240;
  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_SGA    = 8'd3;
  localparam logic [7:0] INTR_CHAR  = 8'd3;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_NUL   = 8'd0;

  localparam logic DEST_TERM = 1'b0;
  localparam logic DEST_NET  = 1'b1;

  localparam logic [1:0] VERB_WILL = 2'd0;
  localparam logic [1:0] VERB_WONT = 2'd1;
  localparam logic [1:0] VERB_DO   = 2'd2;
  localparam logic [1:0] VERB_DONT = 2'd3;

  localparam int AYT_LEN = 9;
  localparam int IDX_W   = 4;
  localparam logic [IDX_W-1:0] CMD_LAST = 4'd2;
  localparam logic [IDX_W-1:0] AYT_LAST = 4'd8;

  typedef enum logic [1:0] {
    K_BYTE = 2'd0,
    K_CMD  = 2'd1,
    K_AYT  = 2'd2
  } kind_t;

  // one queued action: a terminal byte, a three-byte reply or the AYT text
  typedef struct packed {
    kind_t      kind;
    logic [7:0] a;
    logic [7:0] b;
  } action_t;

  function automatic logic [7:0] ayt_char(input logic [IDX_W-1:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = CHAR_CR;
      4'd1:    ch = CHAR_LF;
      4'd2:    ch = 8'h5B;
      4'd3:    ch = 8'h79;
      4'd4:    ch = 8'h65;
      4'd5:    ch = 8'h73;
      4'd6:    ch = 8'h5D;
      4'd7:    ch = CHAR_CR;
      4'd8:    ch = CHAR_LF;
      default: ch = CHAR_NUL;
    endcase
    return ch;
  endfunction

endpackage

// ===== hdl/telnet_command_filter.sv =====
// Telnet command filter top level: parser, action queue and expander.
// A byte's action goes via the action queue and current action to the result register.
// Throughput: one byte accepted per cycle while the queue has room; the expander issues
// one result byte per cycle while not stalled; a WILL/DO reply is 3 bytes, AYT 9 bytes.
// Reset (rst, synchronous) returns the parser to plain data and empties queue and output.
module telnet_command_filter #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [7:0] rx_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       destination,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  logic             accept, push, pop, empty, full;
  tcf_pkg::action_t action, head;

  assign item_stall = full;
  assign accept     = item_valid && !full;

  tcf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .push    (push),
    .action  (action)
  );

  tcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (action),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  tcf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .destination  (destination),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run)
  );

endmodule

// ===== hdl/tcf_front.sv =====
// Byte parser: tracks the Telnet command phase and classifies each byte.
// Emits at most one action per accepted byte. Depends on tcf_pkg.
module tcf_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         rx_byte,
  output logic               push,
  output tcf_pkg::action_t   action
);

  typedef enum logic [4:0] {
    PH_DATA   = 5'b00001,
    PH_IAC    = 5'b00010,
    PH_OPT    = 5'b00100,
    PH_SUB    = 5'b01000,
    PH_SUBIAC = 5'b10000
  } phase_t;

  phase_t     phase, phase_next;
  logic [1:0] verb, verb_next;
  logic       cr_seen, cr_seen_next;
  logic [7:0] diff;

  assign diff = rx_byte - tcf_pkg::CODE_WILL;

  always_comb begin
    phase_next   = phase;
    verb_next    = verb;
    cr_seen_next = cr_seen;
    push         = 1'b0;
    action.kind  = tcf_pkg::K_BYTE;
    action.a     = rx_byte;
    action.b     = rx_byte;
    if (accept) begin
      cr_seen_next = 1'b0;
      if (!(cr_seen && (rx_byte == tcf_pkg::CHAR_LF || rx_byte == tcf_pkg::CHAR_NUL))) begin
        case (phase)
          PH_IAC: begin
            phase_next = PH_DATA;
            if (rx_byte == tcf_pkg::CODE_IAC) begin
              push = 1'b1;
            end else if (rx_byte >= tcf_pkg::CODE_WILL && rx_byte <= tcf_pkg::CODE_DONT) begin
              verb_next  = diff[1:0];
              phase_next = PH_OPT;
            end else if (rx_byte == tcf_pkg::CODE_SB) begin
              phase_next = PH_SUB;
            end else if (rx_byte == tcf_pkg::CODE_IP || rx_byte == tcf_pkg::CODE_BREAK) begin
              push     = 1'b1;
              action.a = tcf_pkg::INTR_CHAR;
            end else if (rx_byte == tcf_pkg::CODE_AYT) begin
              push        = 1'b1;
              action.kind = tcf_pkg::K_AYT;
            end
          end
          PH_OPT: begin
            phase_next  = PH_DATA;
            action.kind = tcf_pkg::K_CMD;
            if (verb == tcf_pkg::VERB_WILL && rx_byte != tcf_pkg::OPT_SGA) begin
              push     = 1'b1;
              action.a = tcf_pkg::CODE_DONT;
            end else if (verb == tcf_pkg::VERB_DO && rx_byte != tcf_pkg::OPT_ECHO &&
                         rx_byte != tcf_pkg::OPT_SGA) begin
              push     = 1'b1;
              action.a = tcf_pkg::CODE_WONT;
            end
          end
          PH_SUB: begin
            if (rx_byte == tcf_pkg::CODE_IAC) begin
              phase_next = PH_SUBIAC;
            end
          end
          PH_SUBIAC: begin
            phase_next = (rx_byte == tcf_pkg::CODE_SE) ? PH_DATA : PH_SUB;
          end
          default: begin
            // plain data
            phase_next = PH_DATA;
            if (rx_byte == tcf_pkg::CODE_IAC) begin
              phase_next = PH_IAC;
            end else begin
              push = 1'b1;
              if (rx_byte == tcf_pkg::CHAR_CR) begin
                cr_seen_next = 1'b1;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_DATA;
      verb    <= tcf_pkg::VERB_WILL;
      cr_seen <= 1'b0;
    end else begin
      phase   <= phase_next;
      verb    <= verb_next;
      cr_seen <= cr_seen_next;
    end
  end

endmodule

// ===== hdl/tcf_queue.sv =====
// Short action queue between the parser and the expander.
// Circular buffer with head read; depends on tcf_pkg.
module tcf_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tcf_pkg::action_t  push_data,
  input  logic              pop,
  output tcf_pkg::action_t  head,
  output logic              empty,
  output logic              full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  tcf_pkg::action_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_FULL);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/tcf_back.sv =====
// Expander: turns queued actions into result bytes, one per cycle while not stalled,
// into a registered output stage. Depends on tcf_pkg.
module tcf_back (
  input  logic              clk,
  input  logic              rst,
  input  tcf_pkg::action_t  head,
  input  logic              empty,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_stall,
  output logic              destination,
  output logic [7:0]        out_byte,
  output logic              last_of_run
);

  tcf_pkg::action_t             cur;
  logic                         cur_valid;
  logic [tcf_pkg::IDX_W-1:0]    idx;
  logic                         load;
  logic                         r_dest, r_last;
  logic [7:0]                   r_byte;

  always_comb begin
    r_dest = tcf_pkg::DEST_NET;
    r_byte = tcf_pkg::CODE_IAC;
    r_last = 1'b0;
    case (cur.kind)
      tcf_pkg::K_BYTE: begin
        r_dest = tcf_pkg::DEST_TERM;
        r_byte = cur.a;
        r_last = 1'b1;
      end
      tcf_pkg::K_CMD: begin
        r_last = (idx == tcf_pkg::CMD_LAST);
        if (idx == 4'd1) begin
          r_byte = cur.a;
        end else if (idx == tcf_pkg::CMD_LAST) begin
          r_byte = cur.b;
        end
      end
      tcf_pkg::K_AYT: begin
        r_byte = tcf_pkg::ayt_char(idx);
        r_last = (idx == tcf_pkg::AYT_LAST);
      end
      default: r_last = 1'b1;
    endcase
  end

  assign load = cur_valid && (!result_valid || !result_stall);
  assign pop  = !empty && (!cur_valid || (load && r_last));

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (load) begin
      destination <= r_dest;
      out_byte    <= r_byte;
      last_of_run <= r_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid    <= 1'b0;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (load) begin
        if (r_last) begin
          cur_valid <= 1'b0;
          idx       <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> idx <= tcf_pkg::AYT_LAST)
    else $error("expander index out of range");

  a_byte_single: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && cur.kind == tcf_pkg::K_BYTE) |-> idx == '0)
    else $error("single-byte action advanced its index");

  a_pop_when_done: assert property (@(posedge clk) disable iff (rst)
    (pop && cur_valid) |-> (load && r_last))
    else $error("action replaced before its last byte");

endmodule
